### hdl/kms_pkg.sv
// Shared types and constants for the k-way merge select unit.
// Depends on nothing; every other file of the block imports it.
package kms_pkg;

  // Fixed field widths of the streaming and configuration ports.
  localparam int RUN_W          = 3;
  localparam int CFG_W          = 4;
  localparam int CFG_TDATA_W    = 8;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Defaults for the top-level parameters.
  localparam int MAX_RUNS_DEF     = 8;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef enum logic {
    MODE_RECORD  = 1'b0,
    MODE_EXHAUST = 1'b1
  } mode_t;

  // Classification of one item, made by the front end.
  typedef struct packed {
    mode_t            mode;
    logic [RUN_W-1:0] run;
    logic             in_range;
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

endpackage

### hdl/kms_front.sv
// Front end of the merge select unit: configuration register and item intake.
// Depends on kms_pkg; feeds kms_fifo.
module kms_front #(
  parameter int MAX_RUNS     = kms_pkg::MAX_RUNS_DEF,
  parameter int KEY_BITS     = kms_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = kms_pkg::PAYLOAD_BITS_DEF,
  localparam int RUN_CW      = $clog2(MAX_RUNS + 1),
  localparam int IN_TDATA_W  = ((kms_pkg::RUN_W + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int QW          = KEY_BITS + PAYLOAD_BITS + kms_pkg::CTL_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_tvalid,
  output logic                           cfg_tready,
  input  logic [kms_pkg::CFG_TDATA_W-1:0] cfg_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,
  input  logic [IN_TDATA_W-1:0]          in_tdata,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [QW-1:0]                  q_wdata,
  output logic [RUN_CW-1:0]              run_cnt
);
  import kms_pkg::*;

  logic [CFG_W-1:0]        cfg_r;
  item_ctl_t               ctl;
  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] payload;

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_tvalid) begin
      cfg_r <= cfg_tdata[CFG_W-1:0];
    end
  end

  // A register value of zero behaves as one run, values above the limit as the limit.
  always_comb begin
    if (cfg_r == '0) begin
      run_cnt = RUN_CW'(1);
    end else if (32'(cfg_r) > 32'(MAX_RUNS)) begin
      run_cnt = RUN_CW'(MAX_RUNS);
    end else begin
      run_cnt = RUN_CW'(cfg_r);
    end
  end

  always_comb begin
    ctl.mode     = mode_t'(in_tuser);
    ctl.run      = in_tdata[RUN_W-1:0];
    ctl.in_range = 32'(ctl.run) < 32'(run_cnt);
    key          = in_tdata[RUN_W +: KEY_BITS];
    payload      = in_tdata[RUN_W + KEY_BITS +: PAYLOAD_BITS];
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_wdata   = {key, payload, ctl};

endmodule

### hdl/kms_fifo.sv
// Two-entry queue between the front end and the selection engine.
// Imports kms_pkg but uses none of it; its width W is handed in by its parent.
module kms_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import kms_pkg::*;

  logic [W-1:0] data_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

### hdl/kms_back.sv
// Selection engine: head store, run marks, linear minimum scan and result register.
// Depends on kms_pkg; takes classified items from kms_fifo.
module kms_back #(
  parameter int MAX_RUNS     = kms_pkg::MAX_RUNS_DEF,
  parameter int KEY_BITS     = kms_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = kms_pkg::PAYLOAD_BITS_DEF,
  localparam int RUN_CW      = $clog2(MAX_RUNS + 1),
  localparam int QW          = KEY_BITS + PAYLOAD_BITS + kms_pkg::CTL_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [RUN_CW-1:0]         run_cnt,
  input  logic                      q_empty,
  input  logic [QW-1:0]             q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [KEY_BITS-1:0]       out_key,
  output logic [PAYLOAD_BITS-1:0]   out_payload,
  output logic [kms_pkg::RUN_W-1:0] out_source_run,
  output logic                      out_all_done
);
  import kms_pkg::*;

  localparam int RUN_IW = $clog2(MAX_RUNS);
  localparam int MW     = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_DONE
  } state_t;

  state_t                  state_r;
  logic [MAX_RUNS-1:0]     valid_r;
  logic [MAX_RUNS-1:0]     fin_r;
  logic [RUN_IW-1:0]       idx_r;
  logic                    cmp_v_r;
  logic [RUN_IW-1:0]       cmp_idx_r;
  logic [MW-1:0]           rd_word_r;
  logic [KEY_BITS-1:0]     best_key_r;
  logic [PAYLOAD_BITS-1:0] best_pay_r;
  logic [RUN_IW-1:0]       best_idx_r;
  logic                    have_r;
  logic                    out_valid_r;
  logic [KEY_BITS-1:0]     out_key_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [RUN_W-1:0]        out_run_r;
  logic                    out_done_r;

  logic [MW-1:0]           head_mem [MAX_RUNS];

  item_ctl_t               ctl;
  logic [PAYLOAD_BITS-1:0] q_pay;
  logic [KEY_BITS-1:0]     q_key;
  logic [RUN_IW-1:0]       hidx;
  logic [MAX_RUNS-1:0]     used_mask;
  logic [MAX_RUNS-1:0]     hsel;
  logic                    acc;
  logic                    all_fin;
  logic                    ready_now;
  logic                    have_now;
  logic                    last_idx;
  logic                    take;
  logic                    out_free;
  logic                    emit_go;
  logic                    mem_we;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  always_comb begin
    ctl   = item_ctl_t'(q_rdata[CTL_W-1:0]);
    q_pay = q_rdata[CTL_W +: PAYLOAD_BITS];
    q_key = q_rdata[CTL_W + PAYLOAD_BITS +: KEY_BITS];
    hidx  = RUN_IW'(ctl.run);
    for (int i = 0; i < MAX_RUNS; i++) begin
      used_mask[i] = 32'(i) < 32'(run_cnt);
      hsel[i]      = 32'(i) == 32'(hidx);
    end
  end

  assign q_pop  = (state_r == ST_IDLE) && !q_empty;
  // An item counts only for a run in use whose head is empty and that is not finished.
  assign acc    = ctl.in_range && !valid_r[hidx] && !fin_r[hidx];
  assign mem_we = q_pop && acc && (ctl.mode == MODE_RECORD);

  assign all_fin   = &(fin_r | hsel | ~used_mask);
  assign ready_now = &(valid_r | fin_r | ~used_mask);
  assign have_now  = |(~fin_r & used_mask);
  assign last_idx  = 32'(idx_r) == (32'(run_cnt) - 32'd1);

  assign rd_key = rd_word_r[KEY_BITS-1:0];
  assign rd_pay = rd_word_r[KEY_BITS +: PAYLOAD_BITS];
  // Strict less-than keeps the lowest run on equal keys, since runs are scanned upward.
  assign take   = cmp_v_r && !fin_r[cmp_idx_r] && (!have_r || (rd_key < best_key_r));
  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = ((state_r == ST_EMIT) || (state_r == ST_DONE)) && out_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      head_mem[hidx] <= {q_pay, q_key};
    end
    rd_word_r <= head_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      fin_r       <= '0;
      cmp_v_r     <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      cmp_v_r   <= state_r == ST_SCAN;
      cmp_idx_r <= idx_r;
      if (take) begin
        best_key_r <= rd_key;
        best_pay_r <= rd_pay;
        best_idx_r <= cmp_idx_r;
        have_r     <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= ST_CHECK;
            if (acc && ctl.mode == MODE_RECORD) begin
              valid_r[hidx] <= 1'b1;
            end else if (acc) begin
              fin_r[hidx] <= 1'b1;
              if (all_fin) begin
                state_r <= ST_DONE;
              end
            end
          end
        end
        ST_CHECK: begin
          if (ready_now && have_now) begin
            idx_r   <= '0;
            have_r  <= 1'b0;
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          idx_r <= idx_r + RUN_IW'(1);
          if (last_idx) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // The last head read is compared in this cycle.
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r         <= 1'b1;
            out_key_r           <= best_key_r;
            out_pay_r           <= best_pay_r;
            out_run_r           <= RUN_W'(best_idx_r);
            out_done_r          <= 1'b0;
            valid_r[best_idx_r] <= 1'b0;
            state_r             <= ST_IDLE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_key_r   <= '0;
            out_pay_r   <= '0;
            out_run_r   <= '0;
            out_done_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key        = out_key_r;
  assign out_payload    = out_pay_r;
  assign out_source_run = out_run_r;
  assign out_all_done   = out_done_r;

  // A done result is only raised once every run in use is finished.
  a_done_all_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (&(fin_r | ~used_mask)))
    else $error("done result while a run in use is unfinished");

  // The scan only runs while every unfinished run in use holds a head.
  a_scan_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ready_now)
    else $error("head scan started with an empty head");

  // Emitting a record empties the head of its run.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> !valid_r[$past(best_idx_r)])
    else $error("emitted head still marked valid");

  // Finished marks only clear on reset.
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (($past(fin_r) & ~fin_r) == '0))
    else $error("finished mark cleared");

endmodule

### hdl/k_way_merge_select_unit.sv
// Top level of the k-way merge select unit: front end, item queue and selection engine.
// Depends on kms_pkg, kms_front, kms_fifo and kms_back.
//
//  channel | direction | handshake             | contents
//  --------+-----------+-----------------------+--------------------------------------
//  cfg     | in        | cfg_tvalid/cfg_tready | runs_in_use in tdata[3:0]
//  in      | in        | in_tvalid/in_tready   | tuser: mode; tdata: run, key, payload
//  out     | out       | out_tvalid/out_tready | tuser: all_done; tdata: key, payload, source_run
//
// An item after which every unfinished run in use holds a head starts a scan in the
// engine over runs_in_use runs (clamped to 1..MAX_RUNS) by the single key comparator
// that walks the head memory one run per cycle.
// Other items need no scan. A two-entry queue lets the input run ahead meanwhile.
// Reset is synchronous and clears all marks; the head memory is not cleared.
// A stalled output holds the engine before it emits; the queue behind it fills and then holds the input.
module k_way_merge_select_unit #(
  parameter int MAX_RUNS     = kms_pkg::MAX_RUNS_DEF,
  parameter int KEY_BITS     = kms_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = kms_pkg::PAYLOAD_BITS_DEF,
  localparam int IN_TDATA_W  = ((kms_pkg::RUN_W + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((kms_pkg::RUN_W + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_tvalid,
  output logic                            cfg_tready,
  input  logic [kms_pkg::CFG_TDATA_W-1:0] cfg_tdata,   // runs_in_use, zero padded
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,    // mode
  input  logic [IN_TDATA_W-1:0]           in_tdata,    // run, key, payload, zero padded
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tuser,   // all_done
  output logic [OUT_TDATA_W-1:0]          out_tdata    // out_key, out_payload, source_run
);
  import kms_pkg::*;

  localparam int RUN_CW = $clog2(MAX_RUNS + 1);
  localparam int QW     = KEY_BITS + PAYLOAD_BITS + CTL_W;

  logic                    q_push;
  logic                    q_pop;
  logic                    q_full;
  logic                    q_empty;
  logic [QW-1:0]           q_wdata;
  logic [QW-1:0]           q_rdata;
  logic [RUN_CW-1:0]       run_cnt;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [RUN_W-1:0]        out_source_run;

  kms_front #(
    .MAX_RUNS     (MAX_RUNS),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata),
    .run_cnt    (run_cnt)
  );

  kms_fifo #(
    .W (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  kms_back #(
    .MAX_RUNS     (MAX_RUNS),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .run_cnt        (run_cnt),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_key        (out_key),
    .out_payload    (out_payload),
    .out_source_run (out_source_run),
    .out_all_done   (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({out_source_run, out_payload, out_key});

endmodule
